/* rtl/core/day_count_calendar_converter_top_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the day count / calendar converter
// Each check is clocked on clk and held off while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef DAY_COUNT_CALENDAR_CONVERTER_TOP_ASSERT_SVH
`define DAY_COUNT_CALENDAR_CONVERTER_TOP_ASSERT_SVH

`ifndef SYNTHESIS
// Same-cycle implication.
`define DCCC_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("dccc: same-cycle check failed");
// Next-cycle implication.
`define DCCC_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("dccc: next-cycle check failed");
`else
`define DCCC_ASSERT_IMP(lbl, ante, cons)
`define DCCC_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

/* rtl/core/dccc_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dccc_pkg
// Shared constants, types and calendar tables for the converter.
// ----------------------------------------------------------------------------
package dccc_pkg;

	localparam int YEAR_W  = 12;
	localparam int MONTH_W = 4;
	localparam int DAY_W   = 5;
	localparam int COUNT_W = 16;

	localparam logic [YEAR_W-1:0]  FIRST_YEAR = 12'd1978;
	localparam logic [YEAR_W-1:0]  LAST_YEAR  = 12'd2099;
	localparam logic [COUNT_W-1:0] MAX_COUNT  = 16'd44559;
	localparam logic [MONTH_W-1:0] LAST_MONTH_IDX = 4'd11;

	localparam logic OP_DATE_TO_COUNT = 1'b0;
	localparam logic OP_COUNT_TO_DATE = 1'b1;

	typedef enum logic [1:0] {
		S_IDLE,
		S_YEAR,
		S_MONTH,
		S_DONE
	} state_t;

	// controller -> datapath
	typedef struct packed {
		logic load;
		logic year_step;
		logic month_step;
		logic out_load;
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic err;
		logic year_done;
		logic month_done;
	} sts_t;

	function automatic logic is_leap(input logic [YEAR_W-1:0] year);
		return (year[1:0] == 2'b00);
	endfunction

	function automatic logic [8:0] year_len(input logic leap);
		return leap ? 9'd366 : 9'd365;
	endfunction

	// month index 0..11; codes 12..15 mean nothing and read as 31
	function automatic logic [DAY_W-1:0] month_len(input logic leap,
			input logic [MONTH_W-1:0] idx);
		logic [DAY_W-1:0] len;
		case (idx)
			4'd1:    len = leap ? 5'd29 : 5'd28;
			4'd3:    len = 5'd30;
			4'd5:    len = 5'd30;
			4'd8:    len = 5'd30;
			4'd10:   len = 5'd30;
			default: len = 5'd31;
		endcase
		return len;
	endfunction

endpackage

/* rtl/core/dccc_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dccc_ctrl
// Sequencer: load, year stepping, month stepping, result hand-off.
// ----------------------------------------------------------------------------
`include "day_count_calendar_converter_top_assert.svh"

module dccc_ctrl import dccc_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	output logic out_valid,
	input  logic out_ready,
	input  sts_t sts,
	output cmd_t cmd
);

	state_t state_q, state_nxt;
	logic   out_valid_q;
	logic   out_free;

	assign out_free = !out_valid_q || out_ready;

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) state_nxt = S_YEAR;
			end
			S_YEAR: begin
				if (sts.err) state_nxt = S_DONE;
				else if (sts.year_done) state_nxt = S_MONTH;
			end
			S_MONTH: begin
				if (sts.month_done) state_nxt = S_DONE;
			end
			S_DONE: begin
				if (out_free) state_nxt = S_IDLE;
			end
			default: state_nxt = S_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		in_ready = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
			end
			S_YEAR: begin
				cmd.year_step = !sts.err && !sts.year_done;
			end
			S_MONTH: begin
				cmd.month_step = !sts.month_done;
			end
			S_DONE: begin
				cmd.out_load = out_free;
			end
			default: cmd = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cmd.out_load) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;

	`DCCC_ASSERT_IMP(a_no_result_overwrite, cmd.out_load, !out_valid_q || out_ready)
	`DCCC_ASSERT_IMP(a_year_step_not_done, cmd.year_step, !sts.year_done && !sts.err)
	`DCCC_ASSERT_NXT(a_load_then_work, cmd.load, state_q == S_YEAR && !in_ready)

endmodule

/* rtl/core/dccc_dp.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dccc_dp
// Operand registers, shared add/subtract accumulator and result register.
// ----------------------------------------------------------------------------
module dccc_dp import dccc_pkg::*; (
	input  logic               clk,
	input  cmd_t               cmd,
	input  logic               opcode,
	input  logic [YEAR_W-1:0]  cal_year,
	input  logic [MONTH_W-1:0] cal_month,
	input  logic [DAY_W-1:0]   cal_day,
	input  logic [COUNT_W-1:0] count_in,
	output sts_t               sts,
	output logic [YEAR_W-1:0]  out_year,
	output logic [MONTH_W-1:0] out_month,
	output logic [DAY_W-1:0]   out_day,
	output logic [COUNT_W-1:0] count_out,
	output logic               range_error
);

	logic               op_q;
	logic               err_q;
	logic [YEAR_W-1:0]  tgt_year_q;
	logic [MONTH_W-1:0] tgt_month_q;
	logic [DAY_W-1:0]   day_q;
	logic [YEAR_W-1:0]  yr_q;
	logic [MONTH_W-1:0] mon_q;
	logic [COUNT_W-1:0] acc_q;

	logic [YEAR_W-1:0]  out_year_q;
	logic [MONTH_W-1:0] out_month_q;
	logic [DAY_W-1:0]   out_day_q;
	logic [COUNT_W-1:0] count_out_q;
	logic               range_error_q;

	logic               in_err;
	logic               cur_leap;
	logic [8:0]         ylen;
	logic [DAY_W-1:0]   mlen;
	logic [COUNT_W-1:0] ylen_ext, mlen_ext;

	// input check: date fields for date to count, count bound otherwise
	always_comb begin
		if (opcode == OP_DATE_TO_COUNT) begin
			in_err = (cal_year < FIRST_YEAR) || (cal_year > LAST_YEAR) ||
				(cal_month == '0) || (cal_month > 4'd12) || (cal_day == '0) ||
				(cal_day > month_len(is_leap(cal_year), cal_month - 4'd1));
		end else begin
			in_err = (count_in > MAX_COUNT);
		end
	end

	assign cur_leap = is_leap(yr_q);
	assign ylen     = year_len(cur_leap);
	assign mlen     = month_len(cur_leap, mon_q);
	assign ylen_ext = {{(COUNT_W-9){1'b0}}, ylen};
	assign mlen_ext = {{(COUNT_W-DAY_W){1'b0}}, mlen};

	always_comb begin
		sts.err = err_q;
		if (op_q == OP_DATE_TO_COUNT) begin
			sts.year_done  = (yr_q == tgt_year_q);
			sts.month_done = (mon_q == tgt_month_q - 4'd1);
		end else begin
			sts.year_done  = (acc_q <= ylen_ext);
			sts.month_done = (mon_q == LAST_MONTH_IDX) || (acc_q <= mlen_ext);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q        <= opcode;
			err_q       <= in_err;
			tgt_year_q  <= cal_year;
			tgt_month_q <= cal_month;
			day_q       <= cal_day;
			yr_q        <= FIRST_YEAR;
			mon_q       <= '0;
			acc_q       <= (opcode == OP_COUNT_TO_DATE) ? count_in + 16'd1 : '0;
		end else if (cmd.year_step) begin
			yr_q  <= yr_q + 12'd1;
			acc_q <= (op_q == OP_DATE_TO_COUNT) ? acc_q + ylen_ext : acc_q - ylen_ext;
		end else if (cmd.month_step) begin
			mon_q <= mon_q + 4'd1;
			acc_q <= (op_q == OP_DATE_TO_COUNT) ? acc_q + mlen_ext : acc_q - mlen_ext;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			range_error_q <= err_q;
			if (err_q) begin
				out_year_q  <= '0;
				out_month_q <= '0;
				out_day_q   <= '0;
				count_out_q <= '0;
			end else if (op_q == OP_DATE_TO_COUNT) begin
				out_year_q  <= '0;
				out_month_q <= '0;
				out_day_q   <= '0;
				count_out_q <= acc_q + {{(COUNT_W-DAY_W){1'b0}}, day_q - 5'd1};
			end else begin
				out_year_q  <= yr_q;
				out_month_q <= mon_q + 4'd1;
				out_day_q   <= acc_q[DAY_W-1:0];
				count_out_q <= '0;
			end
		end
	end

	assign out_year    = out_year_q;
	assign out_month   = out_month_q;
	assign out_day     = out_day_q;
	assign count_out   = count_out_q;
	assign range_error = range_error_q;

endmodule

/* rtl/core/day_count_calendar_converter_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// day_count_calendar_converter_top
// Converts between days since 1 January 1978 and a calendar date.
// ----------------------------------------------------------------------------
// One item at a time, selected by opcode: 0 turns cal_year/cal_month/cal_day
// into count_out, 1 turns count_in into out_year/out_month/out_day. Leap
// years are every fourth year, correct over 1978..2099. A bad date or a count
// past 31 December 2099 sets range_error and zeroes the other result fields;
// fields that an opcode does not produce are zero. One shared 16-bit
// add/subtract accumulator walks the years from 1978 one per cycle, then the
// months one per cycle; a range error skips both walks, and the result
// register loads once it is empty or its result is being taken. in_ready
// is high only while the sequencer is idle, which it reaches in the cycle
// the result turns valid, so the next item can transfer in from that cycle
// on. The result sits in its own register, so the next item may transfer in
// while the previous result still waits for out_ready.
// ----------------------------------------------------------------------------
module day_count_calendar_converter_top import dccc_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	// input channel
	input  logic               in_valid,
	output logic               in_ready,
	input  logic               opcode,
	input  logic [YEAR_W-1:0]  cal_year,
	input  logic [MONTH_W-1:0] cal_month,
	input  logic [DAY_W-1:0]   cal_day,
	input  logic [COUNT_W-1:0] count_in,
	// result channel
	output logic               out_valid,
	input  logic               out_ready,
	output logic [YEAR_W-1:0]  out_year,
	output logic [MONTH_W-1:0] out_month,
	output logic [DAY_W-1:0]   out_day,
	output logic [COUNT_W-1:0] count_out,
	output logic               range_error
);

	cmd_t cmd;
	sts_t sts;

	// sequencer: owns the handshakes and decides each step
	dccc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	// datapath: captures the item, accumulates, holds the result
	dccc_dp u_dp (
		.clk         (clk),
		.cmd         (cmd),
		.opcode      (opcode),
		.cal_year    (cal_year),
		.cal_month   (cal_month),
		.cal_day     (cal_day),
		.count_in    (count_in),
		.sts         (sts),
		.out_year    (out_year),
		.out_month   (out_month),
		.out_day     (out_day),
		.count_out   (count_out),
		.range_error (range_error)
	);

endmodule

/* tb/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Checks the day count / calendar converter in both directions.
// ----------------------------------------------------------------------------
// A queue of requests is filled up front. It starts with a short directed
// list: the span edges, bad years, months and days, leap-day cases, counts on
// month and year ends, and counts past the end of 2099. After that come random
// well-formed dates and counts, plus some raw noise on every field. A sender
// process feeds the queue to the input channel with random gaps. A receiver
// process stalls the result channel at random, and twice it holds off for a
// long stretch so that the converter backs up. Each accepted request is run
// through a local calendar model, and each result transfer is checked against
// the oldest prediction.
// ----------------------------------------------------------------------------
module testbench;
	import dccc_pkg::*;

	// one request as it crosses the input channel
	typedef struct packed {
		logic               op;
		logic [YEAR_W-1:0]  year;
		logic [MONTH_W-1:0] month;
		logic [DAY_W-1:0]   day;
		logic [COUNT_W-1:0] count;
	} date_request_t;

	// one result as it leaves on the output channel
	typedef struct packed {
		logic [YEAR_W-1:0]  year;
		logic [MONTH_W-1:0] month;
		logic [DAY_W-1:0]   day;
		logic [COUNT_W-1:0] count;
		logic               range_err;
	} date_result_t;

	localparam int unsigned TARGET_ITEMS = 1350;
	localparam int unsigned DRAIN_CYCLES = 200;  // beyond the longest year/month walk
	localparam int unsigned HOLD_CYCLES  = 800;

	logic               clk         = 1'b0;
	logic               arst_n      = 1'b0;
	logic               in_valid    = 1'b0;
	logic               in_ready;
	logic               opcode      = OP_DATE_TO_COUNT;
	logic [YEAR_W-1:0]  cal_year    = '0;
	logic [MONTH_W-1:0] cal_month   = '0;
	logic [DAY_W-1:0]   cal_day     = '0;
	logic [COUNT_W-1:0] count_in    = '0;
	logic               out_valid;
	logic               out_ready   = 1'b0;
	logic [YEAR_W-1:0]  out_year;
	logic [MONTH_W-1:0] out_month;
	logic [DAY_W-1:0]   out_day;
	logic [COUNT_W-1:0] count_out;
	logic               range_error;

	date_request_t request_q[$];      // requests still to be offered
	date_result_t  due_results[$];    // predictions waiting for their result
	bit            in_took;           // input transfer at the last rising edge
	bit            out_took;          // result transfer at the last rising edge
	bit            hold_results = 1'b0;
	int unsigned   transfers_in = 0;
	int unsigned   error_count  = 0;
	int unsigned   n_to_count   = 0;
	int unsigned   n_to_date    = 0;
	int unsigned   n_flagged    = 0;

	day_count_calendar_converter_top u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.opcode      (opcode),
		.cal_year    (cal_year),
		.cal_month   (cal_month),
		.cal_day     (cal_day),
		.count_in    (count_in),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.out_year    (out_year),
		.out_month   (out_month),
		.out_day     (out_day),
		.count_out   (count_out),
		.range_error (range_error)
	);

	always #10 clk = ~clk;

	// ------------------------------------------------------------------------
	// Calendar model
	// ------------------------------------------------------------------------

	// every fourth year is a leap year; good for 1901..2099
	function automatic bit leap_year(input int unsigned year);
		return (year % 4) == 0;
	endfunction

	function automatic int unsigned days_in_month(input int unsigned year,
			input int unsigned idx);
		int unsigned lens[12];
		lens = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
		if (idx % 12 == 1 && leap_year(year))
			return 29;
		return lens[idx % 12];
	endfunction

	function automatic date_result_t convert_date(input date_request_t rq);
		date_result_t res;
		int unsigned  span;
		int unsigned  left;
		int unsigned  yr;
		int unsigned  mo;
		res = '0;
		if (rq.op == OP_DATE_TO_COUNT) begin
			if (rq.year < FIRST_YEAR || rq.year > LAST_YEAR || rq.month < 1 ||
					rq.month > 12 || rq.day < 1 ||
					rq.day > days_in_month(rq.year, rq.month - 1)) begin
				res.range_err = 1'b1;
			end else begin
				// whole years, their leap days, earlier months, then the day
				span = rq.year - FIRST_YEAR;
				left = span * 365 + (span + 1) / 4;
				for (mo = 0; mo + 1 < rq.month; mo++)
					left += days_in_month(rq.year, mo);
				left += rq.day - 1;
				res.count = left[COUNT_W-1:0];
			end
		end else begin
			if (rq.count > MAX_COUNT) begin
				res.range_err = 1'b1;
			end else begin
				// strip whole years, then whole months; the rest is the day
				left = rq.count + 1;
				yr = FIRST_YEAR;
				while (left > (leap_year(yr) ? 366 : 365)) begin
					left -= leap_year(yr) ? 366 : 365;
					yr++;
				end
				mo = 0;
				while (mo < 11 && left > days_in_month(yr, mo)) begin
					left -= days_in_month(yr, mo);
					mo++;
				end
				res.year  = yr[YEAR_W-1:0];
				res.month = mo[MONTH_W-1:0] + 1'b1;
				res.day   = left[DAY_W-1:0];
			end
		end
		return res;
	endfunction

	// ------------------------------------------------------------------------
	// Request builders; fields the opcode ignores carry random junk
	// ------------------------------------------------------------------------

	function automatic date_request_t date_item(input int unsigned year,
			input int unsigned month, input int unsigned day);
		date_request_t rq;
		rq.op    = OP_DATE_TO_COUNT;
		rq.year  = year[YEAR_W-1:0];
		rq.month = month[MONTH_W-1:0];
		rq.day   = day[DAY_W-1:0];
		rq.count = COUNT_W'($urandom);
		return rq;
	endfunction

	function automatic date_request_t count_item(input int unsigned count);
		date_request_t rq;
		rq.op    = OP_COUNT_TO_DATE;
		rq.year  = YEAR_W'($urandom);
		rq.month = MONTH_W'($urandom);
		rq.day   = DAY_W'($urandom);
		rq.count = count[COUNT_W-1:0];
		return rq;
	endfunction

	// ------------------------------------------------------------------------
	// Sender: present the next request after a random gap, hold until transfer
	// ------------------------------------------------------------------------
	always @(negedge clk or negedge arst_n) begin : sender
		date_request_t rq;
		int unsigned   send_wait;
		bit            send_burst;
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (!in_valid || in_took) begin
			if (in_valid) begin
				// the offered request just moved; draw the gap before the next
				if ($urandom_range(0, 39) == 0)
					send_burst = !send_burst;
				send_wait = send_burst ? 0 : $urandom_range(0, 14);
			end
			if (send_wait > 0) begin
				send_wait--;
				in_valid <= 1'b0;
			end else if (request_q.size() > 0) begin
				rq = request_q.pop_front();
				opcode    <= rq.op;
				cal_year  <= rq.year;
				cal_month <= rq.month;
				cal_day   <= rq.day;
				count_in  <= rq.count;
				in_valid  <= 1'b1;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// ------------------------------------------------------------------------
	// Receiver: random stall after each result, plus long holds on request
	// ------------------------------------------------------------------------
	always @(negedge clk or negedge arst_n) begin : receiver
		int unsigned recv_wait;
		bit          recv_burst;
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_took) begin
				if ($urandom_range(0, 39) == 0)
					recv_burst = !recv_burst;
				recv_wait = recv_burst ? 0 : $urandom_range(0, 14);
			end
			if (hold_results) begin
				out_ready <= 1'b0;
			end else if (recv_wait > 0) begin
				recv_wait--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// Back up the converter twice: drop ready for a long stretch while the
	// sender keeps offering, so in_ready has to fall.
	initial begin : result_backpressure
		for (int k = 0; k < 2; k++) begin
			wait (transfers_in >= 300 + k * 600);
			@(posedge clk);
			hold_results = 1'b1;
			repeat (HOLD_CYCLES) @(posedge clk);
			hold_results = 1'b0;
		end
	end

	// ------------------------------------------------------------------------
	// Monitor: predict on every input transfer, check every result transfer
	// ------------------------------------------------------------------------
	always @(posedge clk) begin : monitor
		date_result_t got;
		date_result_t want;
		in_took  = arst_n && in_valid && in_ready;
		out_took = arst_n && out_valid && out_ready;
		if (in_took) begin
			due_results.push_back(convert_date('{opcode, cal_year, cal_month,
					cal_day, count_in}));
			transfers_in++;
		end
		if (out_took) begin
			got = '{out_year, out_month, out_day, count_out, range_error};
			if (due_results.size() == 0) begin
				error_count++;
				if (error_count <= 10)
					$display("%0t: result with nothing pending: y=%0d m=%0d d=%0d n=%0d err=%0b",
						$realtime, got.year, got.month, got.day, got.count,
						got.range_err);
			end else begin
				want = due_results.pop_front();
				if (got.year !== want.year || got.month !== want.month ||
						got.day !== want.day || got.count !== want.count ||
						got.range_err !== want.range_err) begin
					error_count++;
					if (error_count <= 10)
						$display({"%0t: mismatch: expected y=%0d m=%0d d=%0d n=%0d err=%0b,",
							" got y=%0d m=%0d d=%0d n=%0d err=%0b"}, $realtime,
							want.year, want.month, want.day, want.count,
							want.range_err, got.year, got.month, got.day,
							got.count, got.range_err);
				end
				if (want.range_err)
					n_flagged++;
				else if (want.year == 0)
					n_to_count++;
				else
					n_to_date++;
			end
		end
	end

	// ------------------------------------------------------------------------
	// Stimulus and end of run
	// ------------------------------------------------------------------------
	initial begin : stimulus
		date_request_t rq;
		date_result_t  edge_res;
		int unsigned   yr;
		int unsigned   mo;
		int unsigned   dy;
		int unsigned   pick;
		int unsigned   total;

		// span edges
		request_q.push_back(date_item(1978, 1, 1));
		request_q.push_back(date_item(2099, 12, 31));
		request_q.push_back(count_item(0));
		request_q.push_back(count_item(MAX_COUNT));
		// bad years, including the widest field values
		request_q.push_back(date_item(1977, 12, 31));
		request_q.push_back(date_item(2100, 1, 1));
		request_q.push_back(date_item(0, 1, 1));
		request_q.push_back(date_item(4095, 15, 31));
		// bad months and days, and one good January 31
		request_q.push_back(date_item(1990, 0, 10));
		request_q.push_back(date_item(1990, 13, 10));
		request_q.push_back(date_item(1990, 15, 1));
		request_q.push_back(date_item(1990, 6, 0));
		request_q.push_back(date_item(1990, 4, 31));
		request_q.push_back(date_item(1990, 1, 31));
		// leap day: fine in a leap year, bad otherwise; February 30 is bad even then
		request_q.push_back(date_item(1980, 2, 29));
		request_q.push_back(date_item(1979, 2, 29));
		request_q.push_back(date_item(2000, 2, 30));
		// counts on the last day of a month and of a year, a year's first day, and the leap day
		request_q.push_back(count_item(30));
		request_q.push_back(count_item(364));
		request_q.push_back(count_item(365));
		request_q.push_back(count_item(789));
		// counts past the end of 2099
		request_q.push_back(count_item(MAX_COUNT + 1));
		request_q.push_back(count_item(16'hFFFF));

		// Mostly well-formed dates and counts, leaning on month ends, with
		// some raw noise on every field.
		while (request_q.size() < TARGET_ITEMS) begin
			pick = $urandom_range(0, 99);
			yr = $urandom_range(FIRST_YEAR, LAST_YEAR);
			mo = $urandom_range(1, 12);
			dy = ($urandom_range(0, 3) == 0) ? days_in_month(yr, mo - 1) :
				$urandom_range(1, days_in_month(yr, mo - 1));
			if (pick < 40) begin
				rq = date_item(yr, mo, dy);
			end else if (pick < 60) begin
				rq = count_item($urandom_range(0, MAX_COUNT));
			end else if (pick < 80) begin
				// turn a chosen date into its count to land on month edges
				edge_res = convert_date(date_item(yr, mo, dy));
				rq = count_item(edge_res.count);
			end else if (pick < 90) begin
				rq = date_item($urandom, $urandom, $urandom);
				if ($urandom_range(0, 1) == 0)
					rq.year = YEAR_W'($urandom_range(FIRST_YEAR - 2, LAST_YEAR + 2));
			end else begin
				rq = count_item($urandom);
			end
			request_q.push_back(rq);
		end
		total = request_q.size();

		repeat (4) @(posedge clk);
		#5 arst_n = 1'b1;

		wait (transfers_in == total);
		wait (due_results.size() == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("covered %0d date-to-count and %0d count-to-date conversions,",
			n_to_count, n_to_date);
		$display("%0d inputs flagged out of range, two long result stalls", n_flagged);
		if (error_count == 0) begin
			$display("testbench: clean");
		end else begin
			$display("%0d failures", error_count);
			$display("testbench: errors");
		end
		$finish;
	end

	// Watchdog far beyond the slowest legal run.
	initial begin : watchdog
		#20_000_000;
		$display("testbench: errors");
		$finish;
	end

endmodule
